// ===== sv/ppi_pkg.sv =====
// Package for the polygon point-inclusion core.
// Holds the item kind codes and the fixed stream field widths.
// It depends on nothing else.
`timescale 1ns / 1ps

package ppi_pkg;

  localparam int FIELD_BITS    = 24;
  localparam int INDEX_BITS    = 4;
  localparam int KIND_BITS     = 2;
  localparam int CFG_BITS      = 5;
  localparam int IN_DATA_BITS  = 152;
  localparam int OUT_DATA_BITS = 8;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_WRITE = 2'd0,
    KIND_TEST  = 2'd1,
    KIND_MOVE  = 2'd2
  } kind_e;

endpackage

// ===== sv/ppi_vertex_mem.sv =====
// Vertex store of the polygon point-inclusion core.
// One write port and one read port with registered read data; x and y share a word.
// It depends on no package.
`timescale 1ns / 1ps

module ppi_vertex_mem #(
  parameter int DEPTH      = 16,
  parameter int COORD_BITS = 24,
  parameter int AW         = 4
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [COORD_BITS-1:0] wx_i,
  input  logic [COORD_BITS-1:0] wy_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [COORD_BITS-1:0] rx_o,
  output logic [COORD_BITS-1:0] ry_o
);

  logic [2*COORD_BITS-1:0] mem_q [DEPTH];
  logic [2*COORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wy_i, wx_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rx_o = rdata_q[COORD_BITS-1:0];
  assign ry_o = rdata_q[2*COORD_BITS-1:COORD_BITS];

endmodule

// ===== sv/ppi_mul.sv =====
// Shared signed multiplier of the polygon point-inclusion core.
// Takes one operand pair per enabled cycle and registers the full product.
// It depends on no package.
`timescale 1ns / 1ps

module ppi_mul #(
  parameter int W = 25
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (2*W)'(a_i) * (2*W)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/polygon_point_inclusion_core.sv =====
// Top level of the polygon point-inclusion core (even-odd ray casting).
// Uses ppi_pkg, ppi_vertex_mem and ppi_mul.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: kind; tdata: vertex and point fields
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: inside_res
// cfg       in   cfg_we_i                     cfg_wdata_i: vertex_count
//
// Each test edge goes through operand setup, two passes through the single shared multiplier
// and a compare; the single read port of the vertex store feeds one vertex per edge.
// Reset clears the control state and the vertex count; the vertex store is not cleared.
// Input is accepted only while the sequencer is idle, and one result may wait in the
// output register while the next item is accepted.
`timescale 1ns / 1ps

module polygon_point_inclusion_core #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: vertex_index[3:0], vertex_x[27:4], vertex_y[51:28],
  // point_a[75:52], point_b[99:76], shift_x[123:100], shift_y[147:124], zero fill.
  input  logic [ppi_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // Fields from bit 0: kind[1:0].
  input  logic [ppi_pkg::KIND_BITS-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: inside_res[0], zero fill.
  output logic [ppi_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [ppi_pkg::CFG_BITS-1:0]       cfg_wdata_i
);

  localparam int W  = COORD_BITS + 1;
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int FB = ppi_pkg::FIELD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_OPS,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_FIN,
    S_MOVE
  } state_e;

  function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [FB-1:0] f);
    return COORD_BITS'($signed(f));
  endfunction

  state_e                         state_q;
  logic [AW-1:0]                  idx_q;
  logic                           inside_q;
  logic                           out_valid_q;
  logic                           out_res_q;
  logic [ppi_pkg::CFG_BITS-1:0]   count_q;

  logic signed [COORD_BITS-1:0]   pa_q, pb_q;
  logic [COORD_BITS-1:0]          sx_q, sy_q;
  logic signed [COORD_BITS-1:0]   prev_x_q, prev_y_q;
  logic signed [W-1:0]            opa1_q, opb1_q, opa2_q, opb2_q;
  logic                           cross_q;
  logic signed [2*W-1:0]          lhs_q;

  logic                           in_fire;
  ppi_pkg::kind_e                 in_kind;
  logic [ppi_pkg::INDEX_BITS-1:0] in_index;
  logic                           index_ok;
  logic [NW-1:0]                  n_eff;
  logic                           n_zero;
  logic [AW-1:0]                  last_addr;

  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_waddr, mem_raddr;
  logic [COORD_BITS-1:0]          mem_wx, mem_wy;
  logic [COORD_BITS-1:0]          rd_x, rd_y;

  logic signed [COORD_BITS-1:0]   xi, yi;
  logic                           y_neg;
  logic signed [W-1:0]            op_ax, op_d, op_dy, op_ex;
  logic                           op_cross;

  logic                           mul_en;
  logic signed [W-1:0]            mul_a, mul_b;
  logic signed [2*W-1:0]          prod;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_kind  = ppi_pkg::kind_e'(s_axis_tuser);
  assign in_index = s_axis_tdata[3:0];
  assign index_ok = (32'(in_index) < MAX_VERTICES);

  assign n_eff     = (32'(count_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_q);
  assign n_zero    = (n_eff == '0);
  assign last_addr = AW'(n_eff - NW'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(in_index);
    mem_wx    = to_coord(s_axis_tdata[27:4]);
    mem_wy    = to_coord(s_axis_tdata[51:28]);
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            ppi_pkg::KIND_WRITE: begin
              mem_we = index_ok;
            end
            ppi_pkg::KIND_TEST: begin
              mem_re    = !n_zero;
              mem_raddr = last_addr;
            end
            ppi_pkg::KIND_MOVE: begin
              mem_re    = !n_zero;
              mem_raddr = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_PRIME: begin
        mem_re = 1'b1;
      end
      S_CMP: begin
        mem_re    = (idx_q != last_addr);
        mem_raddr = idx_q + AW'(1);
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wx    = rd_x + sx_q;
        mem_wy    = rd_y + sy_q;
        mem_re    = (idx_q != last_addr);
        mem_raddr = idx_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  ppi_vertex_mem #(
    .DEPTH      (MAX_VERTICES),
    .COORD_BITS (COORD_BITS),
    .AW         (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wx_i    (mem_wx),
    .wy_i    (mem_wy),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rx_o    (rd_x),
    .ry_o    (rd_y)
  );

  // Edge operands: the current vertex comes from the store, the previous one from a register.
  // The sign of the vertical extent is folded into both the extent and the point offset.
  assign xi       = $signed(rd_x);
  assign yi       = $signed(rd_y);
  assign y_neg    = (prev_y_q < yi);
  assign op_ax    = W'(pa_q) - W'(xi);
  assign op_ex    = W'(prev_x_q) - W'(xi);
  assign op_d     = y_neg ? (W'(yi) - W'(prev_y_q)) : (W'(prev_y_q) - W'(yi));
  assign op_dy    = y_neg ? (W'(yi) - W'(pb_q)) : (W'(pb_q) - W'(yi));
  assign op_cross = (yi > pb_q) != (prev_y_q > pb_q);

  assign mul_en = (state_q == S_MUL1) || (state_q == S_MUL2);
  assign mul_a  = (state_q == S_MUL1) ? opa1_q : opa2_q;
  assign mul_b  = (state_q == S_MUL1) ? opb1_q : opb2_q;

  ppi_mul #(
    .W (W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= 1'b0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (in_kind)
              ppi_pkg::KIND_TEST: begin
                inside_q <= 1'b0;
                idx_q    <= '0;
                state_q  <= n_zero ? S_FIN : S_PRIME;
              end
              ppi_pkg::KIND_MOVE: begin
                idx_q <= '0;
                if (!n_zero) begin
                  state_q <= S_MOVE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PRIME: state_q <= S_OPS;
        S_OPS:   state_q <= S_MUL1;
        S_MUL1:  state_q <= S_MUL2;
        S_MUL2:  state_q <= S_CMP;
        S_CMP: begin
          if (cross_q && (lhs_q < prod)) begin
            inside_q <= !inside_q;
          end
          if (idx_q == last_addr) begin
            state_q <= S_FIN;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_OPS;
          end
        end
        S_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_res_q   <= inside_q;
            state_q     <= S_IDLE;
          end
        end
        S_MOVE: begin
          if (idx_q == last_addr) begin
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_fire) begin
      pa_q <= to_coord(s_axis_tdata[75:52]);
      pb_q <= to_coord(s_axis_tdata[99:76]);
      sx_q <= to_coord(s_axis_tdata[123:100]);
      sy_q <= to_coord(s_axis_tdata[147:124]);
    end
    if ((state_q == S_PRIME) || (state_q == S_CMP)) begin
      prev_x_q <= xi;
      prev_y_q <= yi;
    end
    if (state_q == S_OPS) begin
      opa1_q  <= op_ax;
      opb1_q  <= op_d;
      opa2_q  <= op_ex;
      opb2_q  <= op_dy;
      cross_q <= op_cross;
    end
    if (state_q == S_MUL2) begin
      lhs_q <= prod;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ppi_pkg::OUT_DATA_BITS-1){1'b0}}, out_res_q};

  a_write_only_idle_or_move: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_IDLE) || (state_q == S_MOVE))
  ) else $error("vertex store written during a test walk");

  a_fin_loads_free_slot: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && !out_valid_q) |=> (out_valid_q && (state_q == S_IDLE))
  ) else $error("finished test did not load a free output register");

  a_lhs_from_first_pass: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL2) |=> ((state_q == S_CMP) && (lhs_q == $past(prod)))
  ) else $error("first product not held for the edge compare");

endmodule

// ===== tb/ppi_inclusion_checker.sv =====
// Checker for the polygon point-inclusion core: it watches the item, result and register
// channels, keeps its own corner store, predicts each inside answer and compares it.
// Depends on ppi_pkg.
`timescale 1ns / 1ps

module ppi_inclusion_checker #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [ppi_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  input  logic [ppi_pkg::KIND_BITS-1:0]     s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [ppi_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [ppi_pkg::CFG_BITS-1:0]      cfg_wdata_i,
  output int                                errors_o,
  output int                                waiting_o
);

  localparam int VX_LSB = ppi_pkg::INDEX_BITS;
  localparam int VY_LSB = VX_LSB + ppi_pkg::FIELD_BITS;
  localparam int PA_LSB = VY_LSB + ppi_pkg::FIELD_BITS;
  localparam int PB_LSB = PA_LSB + ppi_pkg::FIELD_BITS;
  localparam int SX_LSB = PB_LSB + ppi_pkg::FIELD_BITS;
  localparam int SY_LSB = SX_LSB + ppi_pkg::FIELD_BITS;

  typedef logic signed [ppi_pkg::FIELD_BITS-1:0] field_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t a;
    coord_t b;
    logic   answer;
  } probe_t;

  coord_t                       corner_x [MAX_VERTICES];
  coord_t                       corner_y [MAX_VERTICES];
  logic [ppi_pkg::CFG_BITS-1:0] vertex_count;
  probe_t                       inside_due[$];

  function automatic field_t field_at(input int lsb);
    return field_t'(s_axis_tdata[lsb +: ppi_pkg::FIELD_BITS]);
  endfunction

  function automatic int corners_used();
    return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
  endfunction

  // Even-odd rule: the crossing is compared exactly by cross-multiplication, with
  // the sign of the edge's vertical extent folded into both sides.
  function automatic logic point_inside(input coord_t pa, input coord_t pb);
    int     n;
    int     prev;
    logic   odd;
    longint a, b, xi, yi, xp, yp, span, rise;
    n   = corners_used();
    odd = 1'b0;
    a   = pa;
    b   = pb;
    if (n == 0) return 1'b0;
    prev = n - 1;
    for (int k = 0; k < n; k++) begin
      xi = corner_x[k];
      yi = corner_y[k];
      xp = corner_x[prev];
      yp = corner_y[prev];
      if ((yi > b) != (yp > b)) begin
        span = yp - yi;
        rise = b - yi;
        if (span < 0) begin
          span = -span;
          rise = -rise;
        end
        if ((a - xi) * span < (xp - xi) * rise) odd = !odd;
      end
      prev = k;
    end
    return odd;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    errors_o++;
  endtask

  task automatic take_item();
    logic [ppi_pkg::INDEX_BITS-1:0] idx;
    coord_t                         dx;
    coord_t                         dy;
    probe_t                         probe;
    idx = s_axis_tdata[ppi_pkg::INDEX_BITS-1:0];
    case (s_axis_tuser)
      ppi_pkg::KIND_WRITE: begin
        if (idx < MAX_VERTICES) begin
          corner_x[idx] = coord_t'(field_at(VX_LSB));
          corner_y[idx] = coord_t'(field_at(VY_LSB));
        end
      end
      ppi_pkg::KIND_TEST: begin
        probe.a      = coord_t'(field_at(PA_LSB));
        probe.b      = coord_t'(field_at(PB_LSB));
        probe.answer = point_inside(probe.a, probe.b);
        inside_due.push_back(probe);
      end
      ppi_pkg::KIND_MOVE: begin
        dx = coord_t'(field_at(SX_LSB));
        dy = coord_t'(field_at(SY_LSB));
        for (int k = 0; k < corners_used(); k++) begin
          corner_x[k] = corner_x[k] + dx;
          corner_y[k] = corner_y[k] + dy;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic take_result();
    probe_t probe;
    if (inside_due.size() == 0) begin
      report_mismatch($sformatf("inside_res %0b arrived with no test waiting",
                                m_axis_tdata[0]));
    end else begin
      probe = inside_due.pop_front();
      if (m_axis_tdata[0] !== probe.answer) begin
        report_mismatch($sformatf("point (%0d, %0d) count %0d: inside_res %0b, predicted %0b",
                                  probe.a, probe.b, vertex_count, m_axis_tdata[0],
                                  probe.answer));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count = '0;
      inside_due.delete();
      errors_o  = 0;
      waiting_o = 0;
    end else begin
      if (cfg_we_i) vertex_count = cfg_wdata_i;
      // A result can never belong to an item accepted at the same edge.
      if (m_axis_tvalid && m_axis_tready) take_result();
      if (s_axis_tvalid && s_axis_tready) take_item();
      waiting_o = inside_due.size();
    end
  end

endmodule

// ===== tb/polygon_point_inclusion_core_test.sv =====
// Testbench top for the polygon point-inclusion core: drives corner writes, moves, point
// tests, unused item kinds and vertex counts; the verdict is the checker's error count.
// Depends on ppi_pkg, polygon_point_inclusion_core and ppi_inclusion_checker.
`timescale 1ns / 1ps

module polygon_point_inclusion_core_test;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 24;
  localparam int DRAIN_CYCLES = 4 * MAX_VERTICES + 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;

  localparam logic [ppi_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;

  typedef logic signed [ppi_pkg::FIELD_BITS-1:0] field_t;

  localparam field_t COORD_MIN = {1'b1, {(ppi_pkg::FIELD_BITS - 1){1'b0}}};
  localparam field_t COORD_MAX = {1'b0, {(ppi_pkg::FIELD_BITS - 1){1'b1}}};

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [ppi_pkg::IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic [ppi_pkg::KIND_BITS-1:0]     s_axis_tuser  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [ppi_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                              cfg_we_i      = 1'b0;
  logic [ppi_pkg::CFG_BITS-1:0]      cfg_wdata_i   = '0;

  int          errors;
  int          waiting;
  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  int          quiet_cycles       = 0;
  int          used_corners       = 0;
  field_t      shape_x [MAX_VERTICES];
  field_t      shape_y [MAX_VERTICES];
  field_t      hub_x = '0;
  field_t      hub_y = '0;

  polygon_point_inclusion_core #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  ppi_inclusion_checker #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .errors_o     (errors),
    .waiting_o    (waiting)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("polygon_point_inclusion_core test failed");
      $finish;
    end
  end

  function automatic field_t noise();
    return field_t'($urandom);
  endfunction

  function automatic field_t near(input field_t base, input int unsigned spread);
    return base + field_t'(int'($urandom_range(2 * spread)) - int'(spread));
  endfunction

  function automatic int unsigned pick_spread();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(16, 4096);
    if (roll < 90) return $urandom_range(4096, 1 << 20);
    return $urandom_range(1 << 20, 1 << 23);
  endfunction

  task automatic drive_item(input logic [ppi_pkg::KIND_BITS-1:0] kind,
                            input logic [ppi_pkg::INDEX_BITS-1:0] idx,
                            input field_t vx, input field_t vy, input field_t pa,
                            input field_t pb, input field_t sx, input field_t sy);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {4'b0, sy, sx, pb, pa, vy, vx, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    if (kind == ppi_pkg::KIND_WRITE) begin
      shape_x[idx] = vx;
      shape_y[idx] = vy;
    end else if (kind == ppi_pkg::KIND_MOVE) begin
      for (int k = 0; k < used_corners; k++) begin
        shape_x[k] = shape_x[k] + sx;
        shape_y[k] = shape_y[k] + sy;
      end
      hub_x = hub_x + sx;
      hub_y = hub_y + sy;
    end
  endtask

  task automatic write_corner(input int unsigned idx, input field_t x, input field_t y);
    drive_item(ppi_pkg::KIND_WRITE, ppi_pkg::INDEX_BITS'(idx), x, y, noise(), noise(),
               noise(), noise());
  endtask

  task automatic probe_point(input field_t a, input field_t b);
    drive_item(ppi_pkg::KIND_TEST, ppi_pkg::INDEX_BITS'($urandom), noise(), noise(), a, b,
               noise(), noise());
  endtask

  task automatic shift_all(input field_t dx, input field_t dy);
    drive_item(ppi_pkg::KIND_MOVE, ppi_pkg::INDEX_BITS'($urandom), noise(), noise(),
               noise(), noise(), dx, dy);
  endtask

  task automatic send_unused();
    drive_item(KIND_UNUSED, ppi_pkg::INDEX_BITS'($urandom), noise(), noise(), noise(),
               noise(), noise(), noise());
  endtask

  // The count register may only change once the core has finished every item.
  task automatic set_count(input int unsigned value);
    while (waiting != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = ppi_pkg::CFG_BITS'(value);
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    used_corners = (value > MAX_VERTICES) ? MAX_VERTICES : int'(value);
  endtask

  task automatic run_phase();
    int unsigned spread;
    int unsigned roll;
    int unsigned pick;
    int          sent;
    spread = pick_spread();
    hub_x  = noise();
    hub_y  = noise();
    for (int k = 0; k < used_corners; k++) begin
      write_corner(k, near(hub_x, spread), near(hub_y, spread));
    end
    sent = used_corners;
    while (sent < PHASE_ITEMS) begin
      roll = $urandom_range(99);
      pick = $urandom_range(MAX_VERTICES - 1);
      sent++;
      if (roll < 40) begin
        probe_point(near(hub_x, spread + spread / 4), near(hub_y, spread + spread / 4));
      end else if (roll < 55) begin
        probe_point(near(hub_x, spread), shape_y[pick]);
      end else if (roll < 62) begin
        probe_point(shape_x[pick], shape_y[pick]);
      end else if (roll < 66) begin
        probe_point(noise(), noise());
      end else if (roll < 76) begin
        if ($urandom_range(9) == 0) begin
          shift_all(noise(), noise());
        end else begin
          shift_all(near('0, spread / 4), near('0, spread / 4));
        end
      end else if (roll < 95) begin
        write_corner(pick, near(hub_x, spread), near(hub_y, spread));
      end else begin
        send_unused();
        sent--;
      end
    end
  endtask

  initial begin
    int unsigned extreme_counts [6];
    extreme_counts = '{16, 3, 31, 0, 1, 2};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // With no corners in use nothing is read, so the empty polygon comes first.
    probe_point('0, '0);
    shift_all(COORD_MAX, COORD_MIN);
    send_unused();

    write_corner(0, COORD_MIN, COORD_MIN);
    write_corner(1, COORD_MAX, COORD_MIN);
    write_corner(2, COORD_MAX, COORD_MAX);
    write_corner(3, COORD_MIN, COORD_MAX);
    for (int k = 4; k < MAX_VERTICES; k++) begin
      write_corner(k, near('0, 4096), near('0, 4096));
    end

    set_count(4);
    probe_point('0, '0);
    probe_point(COORD_MIN, '0);
    probe_point(COORD_MAX, COORD_MAX);
    probe_point('0, COORD_MIN);
    // Corners at the top of the range wrap around to the bottom.
    shift_all(field_t'(1), field_t'(1));
    probe_point('0, '0);
    set_count(31);
    probe_point('0, '0);
    set_count(1);
    probe_point('0, '0);
    set_count(2);
    probe_point('0, '0);

    for (int p = 0; p < PHASES; p++) begin
      set_count((p < 6) ? extreme_counts[p] : $urandom_range(3, 31));
      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 53;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 53;
        end
        default: begin
          sender_idle_pct    = 8;
          receiver_stall_pct = 8;
        end
      endcase
      run_phase();
    end

    while (waiting != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("polygon_point_inclusion_core test passed");
    end else begin
      $display("polygon_point_inclusion_core test failed");
    end
    $finish;
  end

endmodule
